FILE: rtl/core/indexed_shift_array_assert.svh
// ----------------------------------------------------------------------------
// indexed_shift_array assertion macros
// Concurrent check wrappers; expect clk and rst_n in scope at the point of use.
// ----------------------------------------------------------------------------
`ifndef INDEXED_SHIFT_ARRAY_ASSERT_SVH
`define INDEXED_SHIFT_ARRAY_ASSERT_SVH

`ifndef NO_ASSERTIONS
`define ISA_ASSERT_IMPLY(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("isa assertion failed");
`define ISA_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("isa assertion failed");
`else
`define ISA_ASSERT_IMPLY(lbl, ante, cons)
`define ISA_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

FILE: rtl/core/isa_pkg.sv
// ----------------------------------------------------------------------------
// isa_pkg
// Sizes, operation codes and status codes of the indexed shift array.
// ----------------------------------------------------------------------------
package isa_pkg;

  localparam int DEPTH  = 64;
  localparam int IDX_W  = $clog2(DEPTH);
  localparam int CNT_W  = $clog2(DEPTH + 1);
  localparam int ACT_W  = 3;
  localparam int DATA_W = 8;
  localparam int POS_W  = 6;
  localparam int OCNT_W = 7;
  localparam int STAT_W = 2;

  typedef enum logic [ACT_W-1:0] {
    ACT_PUSH_BACK  = 3'd0,
    ACT_POP_BACK   = 3'd1,
    ACT_PUSH_FRONT = 3'd2,
    ACT_POP_FRONT  = 3'd3,
    ACT_INSERT     = 3'd4,
    ACT_REMOVE     = 3'd5,
    ACT_SET        = 3'd6,
    ACT_GET        = 3'd7
  } action_t;

  typedef enum logic [STAT_W-1:0] {
    ST_DONE  = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2,
    ST_RANGE = 2'd3
  } status_t;

endpackage

FILE: rtl/core/isa_if.sv
// ----------------------------------------------------------------------------
// isa_if
// Valid/ready channels for request and result beats.
// ----------------------------------------------------------------------------
interface isa_in_if import isa_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [ACT_W-1:0]  action;
  logic [DATA_W-1:0] data_in;
  logic [POS_W-1:0]  position;

  modport source (output valid, action, data_in, position, input ready);
  modport sink   (input valid, action, data_in, position, output ready);
endinterface

interface isa_out_if import isa_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [DATA_W-1:0] data_out;
  logic [OCNT_W-1:0] count;
  logic [STAT_W-1:0] status;

  modport source (output valid, data_out, count, status, input ready);
  modport sink   (input valid, data_out, count, status, output ready);
endinterface

FILE: rtl/core/indexed_shift_array.sv
// ----------------------------------------------------------------------------
// indexed_shift_array: byte array with count, shift on insert/remove
// Requests register in stage 1, results in the output register. One beat per
// cycle while results are taken; all cells and count update together.
// Reset clears the count and both stage valids; cell contents stay undefined.
// ----------------------------------------------------------------------------
`include "indexed_shift_array_assert.svh"

module indexed_shift_array import isa_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  isa_in_if.sink    in_beat,
  isa_out_if.source out_beat
);

  logic              s1_valid_r;
  logic [ACT_W-1:0]  s1_action_r;
  logic [DATA_W-1:0] s1_data_r;
  logic [POS_W-1:0]  s1_pos_r;
  logic              s1_advance;
  logic              in_take;

  logic [DATA_W-1:0] cells_r   [DEPTH];
  logic [DATA_W-1:0] cells_nxt [DEPTH];
  logic [CNT_W-1:0]  count_r;
  logic [CNT_W-1:0]  count_nxt;

  logic              out_valid_r;
  logic [DATA_W-1:0] out_data_r;
  logic [OCNT_W-1:0] out_count_r;
  status_t           out_status_r;

  action_t           act;
  status_t           st;
  logic [DATA_W-1:0] dout;
  logic              do_open;
  logic              do_close;
  logic              do_set;
  logic              do_read;
  logic [CNT_W-1:0]  at;
  logic [CNT_W-1:0]  pos_ext;
  logic [IDX_W-1:0]  rd_idx;
  logic              is_full;
  logic              is_empty;

  assign s1_advance     = s1_valid_r && (!out_valid_r || out_beat.ready);
  assign in_beat.ready  = !s1_valid_r || s1_advance;
  assign in_take        = in_beat.valid && in_beat.ready;

  assign out_beat.valid    = out_valid_r;
  assign out_beat.data_out = out_data_r;
  assign out_beat.count    = out_count_r;
  assign out_beat.status   = out_status_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_take) begin
      s1_valid_r <= 1'b1;
    end else if (s1_advance) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_action_r <= in_beat.action;
      s1_data_r   <= in_beat.data_in;
      s1_pos_r    <= in_beat.position;
    end
  end

  // operation decode and checks
  always_comb begin
    act      = action_t'(s1_action_r);
    pos_ext  = CNT_W'(s1_pos_r);
    is_full  = (count_r >= CNT_W'(DEPTH));
    is_empty = (count_r == '0);
    st       = ST_DONE;
    dout     = '0;
    do_open  = 1'b0;
    do_close = 1'b0;
    do_set   = 1'b0;
    do_read  = 1'b0;
    at       = '0;
    rd_idx   = IDX_W'(s1_pos_r);
    unique case (act)
      ACT_PUSH_BACK, ACT_PUSH_FRONT: begin
        if (is_full) begin
          st = ST_FULL;
        end else begin
          do_open = 1'b1;
          at      = (act == ACT_PUSH_BACK) ? count_r : '0;
        end
      end
      ACT_POP_BACK, ACT_POP_FRONT: begin
        if (is_empty) begin
          st = ST_EMPTY;
        end else begin
          do_close = 1'b1;
          at       = (act == ACT_POP_BACK) ? (count_r - CNT_W'(1)) : '0;
        end
      end
      ACT_INSERT: begin
        if (is_full) begin
          st = ST_FULL;
        end else if (pos_ext > count_r) begin
          st = ST_RANGE;
        end else begin
          do_open = 1'b1;
          at      = pos_ext;
        end
      end
      ACT_REMOVE: begin
        if (is_empty) begin
          st = ST_EMPTY;
        end else if (pos_ext >= count_r) begin
          st = ST_RANGE;
        end else begin
          do_close = 1'b1;
          at       = pos_ext;
        end
      end
      ACT_SET: begin
        if (pos_ext >= count_r) begin
          st = ST_RANGE;
        end else begin
          do_set = 1'b1;
        end
      end
      ACT_GET: begin
        if (pos_ext >= count_r) begin
          st = ST_RANGE;
        end else begin
          do_read = 1'b1;
        end
      end
    endcase
    if (do_close) begin
      do_read = 1'b1;
      rd_idx  = at[IDX_W-1:0];
    end
    if (do_read) begin
      dout = cells_r[rd_idx];
    end
  end

  always_comb begin
    count_nxt = count_r;
    if (do_open) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (do_close) begin
      count_nxt = count_r - CNT_W'(1);
    end
  end

  // each cell picks itself, a neighbor or the new byte
  for (genvar k = 0; k < DEPTH; k++) begin : g_cell
    logic [CNT_W-1:0] k_idx;
    assign k_idx = CNT_W'(k);

    always_comb begin
      cells_nxt[k] = cells_r[k];
      if (do_open) begin
        if (k_idx == at) begin
          cells_nxt[k] = s1_data_r;
        end else if (k_idx > at) begin
          if (k > 0) begin
            cells_nxt[k] = cells_r[(k > 0) ? k - 1 : 0];
          end
        end
      end else if (do_close) begin
        if (k_idx >= at) begin
          if (k < DEPTH - 1) begin
            cells_nxt[k] = cells_r[(k < DEPTH - 1) ? k + 1 : k];
          end
        end
      end else if (do_set && (k_idx == pos_ext)) begin
        cells_nxt[k] = s1_data_r;
      end
    end

    always_ff @(posedge clk) begin
      if (s1_advance) begin
        cells_r[k] <= cells_nxt[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else if (s1_advance) begin
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_advance) begin
      out_valid_r <= 1'b1;
    end else if (out_beat.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_advance) begin
      out_data_r   <= dout;
      out_count_r  <= OCNT_W'(count_nxt);
      out_status_r <= st;
    end
  end

  `ISA_ASSERT_IMPLY(a_count_bound, 1'b1, count_r <= CNT_W'(DEPTH))
  `ISA_ASSERT_IMPLY(a_count_tracks_out, out_valid_r, OCNT_W'(count_r) == out_count_r)
  `ISA_ASSERT_IMPLY(a_full_count, out_valid_r && (out_status_r == ST_FULL), count_r == CNT_W'(DEPTH))
  `ISA_ASSERT_NEXT(a_stall_holds, s1_valid_r && !s1_advance, s1_valid_r)

endmodule
